[src/wspf_pkg.sv]
// ----------------------------------------------------------------------------
// wspf_pkg
// Types, register indexes and the microprogram of the wheel speed controller.
// ----------------------------------------------------------------------------
package wspf_pkg;

   localparam int SPEED_W = 16;
   localparam int ERR_W   = SPEED_W + 1;
   localparam int TICK_W  = 16;
   localparam int DUTY_W  = 16;
   localparam int REG_W   = 32;
   localparam int SLEW_W  = 31;
   localparam int PROD_W  = 2 * REG_W;
   localparam int BOUND_W = SLEW_W + TICK_W - 18;
   localparam int CSR_IDX_W = 3;
   localparam int STEP_W  = 3;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_FF_GAIN    = 3'd0;
   localparam csr_idx_type CSR_FF_OFFSET  = 3'd1;
   localparam csr_idx_type CSR_P_GAIN     = 3'd2;
   localparam csr_idx_type CSR_I_GAIN     = 3'd3;
   localparam csr_idx_type CSR_I_FLOOR    = 3'd4;
   localparam csr_idx_type CSR_I_CEILING  = 3'd5;
   localparam csr_idx_type CSR_SLEW_RATE  = 3'd6;

   typedef struct packed {
      logic signed [REG_W-1:0] ff_gain;
      logic signed [REG_W-1:0] ff_offset;
      logic signed [REG_W-1:0] p_gain;
      logic signed [REG_W-1:0] i_gain;
      logic signed [REG_W-1:0] i_floor;
      logic signed [REG_W-1:0] i_ceiling;
      logic [SLEW_W-1:0]       slew_rate;
   } cfg_type;

   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [2:0] {
      A_FF_GAIN, A_P_GAIN, A_I_GAIN, A_SLEW, A_ERROR
   } a_sel_type;

   typedef enum logic [1:0] {
      B_TARGET, B_ERROR, B_ACCUM, B_TICK
   } b_sel_type;

   typedef enum logic [1:0] {
      SUM_HOLD, SUM_OFFSET, SUM_ADD_X16, SUM_ADD
   } sum_op_type;

   typedef struct packed {
      a_sel_type  a_sel;
      b_sel_type  b_sel;
      sum_op_type sum_op;
      logic       acc_update;
      logic       duty_raw;
      logic       finish_ok;
      logic       finish_bad;
      logic       jump_tick_zero;
      step_type   jump_to;
   } ctl_word_type;

   localparam ctl_word_type CTL_NOP = '{
      a_sel: A_FF_GAIN, b_sel: B_TARGET, sum_op: SUM_HOLD, acc_update: 1'b0,
      duty_raw: 1'b0, finish_ok: 1'b0, finish_bad: 1'b0, jump_tick_zero: 1'b0,
      jump_to: '0};

   localparam step_type STEP_BAD = 3'd7;

   // Microprogram: one product per step, accumulated in the step after.
   function automatic ctl_word_type ucode(input step_type step);
      ctl_word_type w;
      w = CTL_NOP;
      case (step)
         3'd0: begin
            w.a_sel = A_ERROR;    w.b_sel = B_TICK;
            w.jump_tick_zero = 1'b1; w.jump_to = STEP_BAD;
         end
         3'd1: begin
            w.a_sel = A_FF_GAIN;  w.b_sel = B_TARGET;
            w.acc_update = 1'b1;  w.sum_op = SUM_OFFSET;
         end
         3'd2: begin
            w.a_sel = A_P_GAIN;   w.b_sel = B_ERROR;  w.sum_op = SUM_ADD_X16;
         end
         3'd3: begin
            w.a_sel = A_I_GAIN;   w.b_sel = B_ACCUM;  w.sum_op = SUM_ADD_X16;
         end
         3'd4: begin
            w.a_sel = A_SLEW;     w.b_sel = B_TICK;   w.sum_op = SUM_ADD;
         end
         3'd5: w.duty_raw = 1'b1;
         3'd6: w.finish_ok = 1'b1;
         3'd7: w.finish_bad = 1'b1;
         default: w = CTL_NOP;
      endcase
      return w;
   endfunction

endpackage

[src/wspf_useq.sv]
// ----------------------------------------------------------------------------
// wspf_useq
// Step counter and microcode fetch; one control word per cycle unless stalled.
// ----------------------------------------------------------------------------
module wspf_useq
   import wspf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         tick_zero,
   input  logic         out_stall,
   output logic         busy,
   output ctl_word_type ctl
);

   logic         busy_ff, busy_in;
   step_type     step_ff, step_in;
   ctl_word_type word;
   logic         finishing;

   always_comb begin
      word      = ucode(step_ff);
      finishing = word.finish_ok | word.finish_bad;
      busy_in   = busy_ff;
      step_in   = step_ff;
      ctl       = CTL_NOP;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = '0;
         end
      end else if (finishing) begin
         // hold the last step while the result slot is still occupied
         if (!out_stall) begin
            ctl     = word;
            busy_in = 1'b0;
            step_in = '0;
         end
      end else begin
         ctl = word;
         if (word.jump_tick_zero && tick_zero) begin
            step_in = word.jump_to;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign busy = busy_ff;

endmodule

[src/wspf_dpath.sv]
// ----------------------------------------------------------------------------
// wspf_dpath
// Operand registers, shared 32x32 multiplier, Q.32 sum, accumulator and slew.
// ----------------------------------------------------------------------------
module wspf_dpath
   import wspf_pkg::*;
#(
   parameter int DUTY_FLOOR   = -16384,
   parameter int DUTY_CEILING = 16384
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [SPEED_W-1:0] target_speed,
   input  logic signed [SPEED_W-1:0] measured_speed,
   input  logic [TICK_W-1:0]         tick_length,
   input  cfg_type                   cfg,
   input  ctl_word_type              ctl,
   output logic                      tick_zero,
   output logic                      done,
   output logic signed [DUTY_W-1:0]  res_duty,
   output logic                      res_status,
   output logic signed [DUTY_W-1:0]  prev_duty
);

   localparam logic signed [PROD_W-1:0] FLOOR_W = PROD_W'(DUTY_FLOOR);
   localparam logic signed [PROD_W-1:0] CEIL_W  = PROD_W'(DUTY_CEILING);

   logic signed [SPEED_W-1:0] tgt_ff, meas_ff;
   logic [TICK_W-1:0]         tick_ff;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [PROD_W-1:0]  prod_ff, sum_ff, sum_in;
   logic signed [REG_W-1:0]   acc_ff, acc_in;
   logic signed [DUTY_W-1:0]  prev_ff, prev_in;
   logic signed [DUTY_W-1:0]  raw_ff, raw_in;
   logic [BOUND_W-1:0]        bound_ff, bound_in;

   logic signed [REG_W-1:0]   mul_a, mul_b;
   logic signed [PROD_W-1:0]  inc_full, ofs_term, braked, q, q_clamp, bound_full;
   logic signed [REG_W+1:0]   acc_sum;
   logic signed [REG_W-1:0]   acc_sat;
   logic signed [BOUND_W:0]   delta, bound_s;
   logic signed [DUTY_W-1:0]  slewed;
   logic                      tgt_zero;

   assign err_in    = {target_speed[SPEED_W-1], target_speed}
                    - {measured_speed[SPEED_W-1], measured_speed};
   assign tick_zero = (tick_ff == '0);
   assign tgt_zero  = (tgt_ff == '0);

   always_comb begin
      case (ctl.a_sel)
         A_FF_GAIN: mul_a = cfg.ff_gain;
         A_P_GAIN:  mul_a = cfg.p_gain;
         A_I_GAIN:  mul_a = cfg.i_gain;
         A_SLEW:    mul_a = $signed({1'b0, cfg.slew_rate});
         A_ERROR:   mul_a = REG_W'(err_ff);
         default:   mul_a = '0;
      endcase
      case (ctl.b_sel)
         B_TARGET: mul_b = REG_W'(tgt_ff);
         B_ERROR:  mul_b = REG_W'(err_ff);
         B_ACCUM:  mul_b = acc_ff;
         B_TICK:   mul_b = $signed({{(REG_W-TICK_W){1'b0}}, tick_ff});
         default:  mul_b = '0;
      endcase
   end

   // accumulator: floor shift, 32-bit saturate, window clamp, zero on target 0
   always_comb begin
      inc_full = prod_ff >>> 12;
      acc_sum  = {{2{acc_ff[REG_W-1]}}, acc_ff} + inc_full[REG_W+1:0];
      if (acc_sum[REG_W+1:REG_W-1] == 3'b000 || acc_sum[REG_W+1:REG_W-1] == 3'b111) begin
         acc_sat = acc_sum[REG_W-1:0];
      end else begin
         acc_sat = {acc_sum[REG_W+1], {(REG_W-1){~acc_sum[REG_W+1]}}};
      end
      acc_in = acc_ff;
      if (ctl.acc_update) begin
         if (tgt_zero) begin
            acc_in = '0;
         end else if (acc_sat < cfg.i_floor) begin
            acc_in = cfg.i_floor;
         end else if (acc_sat > cfg.i_ceiling) begin
            acc_in = cfg.i_ceiling;
         end else begin
            acc_in = acc_sat;
         end
      end
   end

   always_comb begin
      ofs_term = {{16{cfg.ff_offset[REG_W-1]}}, cfg.ff_offset, 16'b0};
      case (ctl.sum_op)
         SUM_OFFSET: begin
            if (tgt_zero) sum_in = '0;
            else if (tgt_ff[SPEED_W-1]) sum_in = -ofs_term;
            else sum_in = ofs_term;
         end
         SUM_ADD_X16: sum_in = sum_ff + (prod_ff <<< 4);
         SUM_ADD:     sum_in = sum_ff + prod_ff;
         default:     sum_in = sum_ff;
      endcase
   end

   // stop braking, Q.32 to Q2.14, duty clamp, slew bound
   always_comb begin
      braked = sum_ff;
      if (tgt_zero) begin
         if (meas_ff > 0 && sum_ff > 0) braked = '0;
         else if (meas_ff < 0 && sum_ff < 0) braked = '0;
      end
      q = braked >>> 18;
      if (q < FLOOR_W) q_clamp = FLOOR_W;
      else if (q > CEIL_W) q_clamp = CEIL_W;
      else q_clamp = q;
      bound_full = prod_ff >>> 18;
      raw_in   = ctl.duty_raw ? q_clamp[DUTY_W-1:0] : raw_ff;
      bound_in = ctl.duty_raw ? bound_full[BOUND_W-1:0] : bound_ff;
   end

   always_comb begin
      delta   = (BOUND_W+1)'(raw_ff) - (BOUND_W+1)'(prev_ff);
      bound_s = $signed({1'b0, bound_ff});
      if (delta > bound_s) begin
         slewed = prev_ff + $signed(bound_ff[DUTY_W-1:0]);
      end else if (delta < -bound_s) begin
         slewed = prev_ff - $signed(bound_ff[DUTY_W-1:0]);
      end else begin
         slewed = raw_ff;
      end
      prev_in    = ctl.finish_ok ? slewed : prev_ff;
      done       = ctl.finish_ok | ctl.finish_bad;
      res_duty   = ctl.finish_ok ? slewed : prev_ff;
      res_status = ctl.finish_bad;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         tgt_ff  <= target_speed;
         meas_ff <= measured_speed;
         tick_ff <= tick_length;
         err_ff  <= err_in;
      end
      prod_ff  <= mul_a * mul_b;
      sum_ff   <= sum_in;
      raw_ff   <= raw_in;
      bound_ff <= bound_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         prev_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         prev_ff <= prev_in;
      end
   end

   assign prev_duty = prev_ff;

endmodule

[src/wheel_speed_pi_feedforward_core.sv]
// ----------------------------------------------------------------------------
// wheel_speed_pi_feedforward_core
// Feedforward plus PI wheel speed controller with anti-windup, stop braking
// and slew limiting, run by a microcoded sequencer over one shared multiplier.
// ----------------------------------------------------------------------------
// Each request runs microcode steps 0 to 6 (0 then 7 for zero tick length);
// no request is taken while the sequencer runs these seven microcode steps,
// which share the single 32x32 multiplier.
// A new request is accepted while the previous result waits on rsp_ready.
// Reset (synchronous): clears config registers, accumulator and last duty.
// ----------------------------------------------------------------------------
module wheel_speed_pi_feedforward_core
   import wspf_pkg::*;
#(
   parameter int DUTY_FLOOR   = -16384,
   parameter int DUTY_CEILING = 16384
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [SPEED_W-1:0] req_target_speed,
   input  logic signed [SPEED_W-1:0] req_measured_speed,
   input  logic [TICK_W-1:0]         req_tick_length,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [DUTY_W-1:0]  rsp_duty,
   output logic                      rsp_status,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [REG_W-1:0]          csr_data
);

   cfg_type                  cfg_ff, cfg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DUTY_W-1:0] rsp_duty_ff;
   logic                     rsp_status_ff;

   logic                     start, busy, tick_zero, out_stall, done, res_status;
   logic signed [DUTY_W-1:0] res_duty, prev_duty;
   ctl_word_type             ctl;

   assign csr_ready = 1'b1;
   assign req_ready = ~busy;
   assign start     = req_valid & ~busy;
   assign out_stall = rsp_valid_ff & ~rsp_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FF_GAIN:   cfg_in.ff_gain   = csr_data;
            CSR_FF_OFFSET: cfg_in.ff_offset = csr_data;
            CSR_P_GAIN:    cfg_in.p_gain    = csr_data;
            CSR_I_GAIN:    cfg_in.i_gain    = csr_data;
            CSR_I_FLOOR:   cfg_in.i_floor   = csr_data;
            CSR_I_CEILING: cfg_in.i_ceiling = csr_data;
            CSR_SLEW_RATE: cfg_in.slew_rate = csr_data[SLEW_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wspf_useq u_useq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .tick_zero (tick_zero),
      .out_stall (out_stall),
      .busy      (busy),
      .ctl       (ctl)
   );

   wspf_dpath #(
      .DUTY_FLOOR   (DUTY_FLOOR),
      .DUTY_CEILING (DUTY_CEILING)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .target_speed   (req_target_speed),
      .measured_speed (req_measured_speed),
      .tick_length    (req_tick_length),
      .cfg            (cfg_ff),
      .ctl            (ctl),
      .tick_zero      (tick_zero),
      .done           (done),
      .res_duty       (res_duty),
      .res_status     (res_status),
      .prev_duty      (prev_duty)
   );

   assign rsp_valid_in = done | out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_duty_ff   <= res_duty;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_duty   = rsp_duty_ff;
   assign rsp_status = rsp_status_ff;

   a_accept_starts_program: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> busy)
      else $error("request accepted but sequencer not running");

   a_invalid_repeats_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_duty == prev_duty)
      else $error("invalid result does not repeat the last duty");

   a_duty_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_duty) >= DUTY_FLOOR && $signed(rsp_duty) <= DUTY_CEILING))
      else $error("duty outside the output limits");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> !(rsp_valid && !rsp_ready))
      else $error("result overwritten while still pending");

endmodule
